// ----- sv/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// types and codes shared by the positional list core and its cells
// ----------------------------------------------------------------------------
package plist_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] position;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_value;
      logic [4:0] length;
   } rsp_type;

   // per-cell controls driven by the core each cycle
   typedef struct packed {
      logic load_prev;
      logic load_next;
      logic load_value;
      logic read_sel;
   } cell_ctrl_type;

endpackage

// ----- sv/positional_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// bounded ordered byte list: clear, append, and insert/delete/read by 1-based position
// ----------------------------------------------------------------------------
// response: the strobe is registered from start and rises in the cycle after it
// throughput: one transaction per cycle, busy never rises; all later cells
//    shift in parallel in the same cycle
// reset: clears the element count and the response strobe; cell contents are
//    left undefined and are never read before being written
module positional_list_insert_delete_core
   import plist_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] slot;
   logic             pos_in_list;
   logic             pos_insertable;
   logic             full;
   logic             ins_ok;
   logic             del_ok;
   logic             rd_ok;
   logic [1:0]       status;
   logic [7:0]       rd_value;

   cell_ctrl_type    ctrl      [CAPACITY];
   logic [7:0]       cell_data [CAPACITY];
   logic [7:0]       cell_rd   [CAPACITY];

   assign busy = 1'b0;

   assign pos_ext        = CMP_W'(req_payload.position);
   assign cnt_ext        = CMP_W'(count_ff);
   assign pos_in_list    = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign pos_insertable = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign full           = (cnt_ext >= CMP_W'(CAPACITY));

   always_comb begin
      ins_ok   = 1'b0;
      del_ok   = 1'b0;
      rd_ok    = 1'b0;
      status   = ST_OK;
      count_in = count_ff;
      slot     = pos_ext - CMP_W'(1);
      case (op_type'(req_payload.operation))
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_APPEND: begin
            slot = cnt_ext;
            if (full) begin
               status = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         OP_INSERT: begin
            if (!pos_insertable) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         OP_DELETE: begin
            if (!pos_in_list) begin
               status = ST_BADPOS;
            end else begin
               del_ok = 1'b1;
            end
         end
         OP_READ: begin
            if (!pos_in_list) begin
               status = ST_BADPOS;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (del_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // per-cell load, shift and read-select controls from the cell's place relative to the slot
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         ctrl[k].load_value = start && ins_ok && (CMP_W'(k) == slot);
         ctrl[k].load_prev  = start && ins_ok && (CMP_W'(k) > slot);
         ctrl[k].load_next  = start && del_ok && (CMP_W'(k) >= slot)
                              && (k < CAPACITY - 1);
         ctrl[k].read_sel   = rd_ok && (CMP_W'(k) == slot);
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      plist_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[g]),
         .prev_data ((g == 0) ? req_payload.value : cell_data[(g == 0) ? 0 : g - 1]),
         .next_data ((g == CAPACITY - 1) ? cell_data[g]
                                         : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
         .value     (req_payload.value),
         .data      (cell_data[g]),
         .read_data (cell_rd[g])
      );
   end

   always_comb begin
      rd_value = 8'd0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_value = rd_value | cell_rd[k];
      end
   end

   always_comb begin
      rsp_in.status     = status;
      rsp_in.read_value = rd_value;
      rsp_in.length     = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= start;
         if (start) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/plist_cell.sv -----
// ----------------------------------------------------------------------------
// plist_cell
// one element slot: holds a byte, takes it from a neighbor or the new value
// ----------------------------------------------------------------------------
module plist_cell
   import plist_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    prev_data,
   input  logic [7:0]    next_data,
   input  logic [7:0]    value,
   output logic [7:0]    data,
   output logic [7:0]    read_data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load_value) begin
         data_in = value;
      end else if (ctrl.load_prev) begin
         data_in = prev_data;
      end else if (ctrl.load_next) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   // masked so the core can or the whole row together
   assign read_data = ctrl.read_sel ? data_ff : 8'd0;

endmodule

// ----- verif/positional_list_insert_delete_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core_tb
// self-checking bench for the positional byte list: a queue of list commands
// is driven with random gaps, every response is checked field by field
// against a local model of the list contents and element count
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core_tb
   import plist_pkg::*;
;

   localparam int CAPACITY = 16;
   localparam int unsigned RANDOM_OPS = 1650;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned END_QUIET_CYCLES = 8;
   localparam logic [2:0] FIRST_UNUSED_OP = 3'(OP_READ) + 3'd1;
   localparam logic [2:0] LAST_UNUSED_OP = 3'b111;

   typedef struct {
      req_type     req;
      int unsigned gap;    // idle cycles after this transaction
      bit          drain;  // hold off until every response is back
   } list_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   list_cmd_type cmd_queue[$];
   rsp_type      expected_rsp[$];
   logic         req_taken = 1'b0;
   int unsigned  idle_left = 0;
   int unsigned  cycle_count = 0;
   int unsigned  error_count = 0;

   // list model state
   logic [7:0]  model_cells[CAPACITY];
   int unsigned model_count = 0;

   // element count as seen by the stimulus generator
   int unsigned gen_len = 0;

   positional_list_insert_delete_core #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type apply_list_op(req_type r);
      rsp_type     res;
      int unsigned p;
      res = '0;
      p = r.position;
      res.status = ST_OK;
      case (r.operation)
         OP_CLEAR: begin
            model_count = 0;
         end
         OP_APPEND: begin
            if (model_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               model_cells[model_count] = r.value;
               model_count++;
            end
         end
         OP_INSERT: begin
            if (p < 1 || p > model_count + 1) begin
               res.status = ST_BADPOS;
            end else if (model_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int j = model_count; j > p - 1; j--)
                  model_cells[j] = model_cells[j-1];
               model_cells[p-1] = r.value;
               model_count++;
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > model_count) begin
               res.status = ST_BADPOS;
            end else begin
               for (int j = p - 1; j + 1 < model_count; j++)
                  model_cells[j] = model_cells[j+1];
               model_count--;
            end
         end
         OP_READ: begin
            if (p < 1 || p > model_count)
               res.status = ST_BADPOS;
            else
               res.read_value = model_cells[p-1];
         end
         default: ;
      endcase
      res.length = 5'(model_count);
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_cmd(logic [2:0] op, logic [7:0] pos, logic [7:0] val,
                          int unsigned gap, bit drain);
      list_cmd_type c;
      c.req.operation = op;
      c.req.position = pos;
      c.req.value = val;
      c.gap = gap;
      c.drain = drain;
      cmd_queue.push_back(c);
      // track length only, so positions can be aimed at the valid range
      case (op)
         OP_CLEAR: gen_len = 0;
         OP_APPEND: if (gen_len < CAPACITY) gen_len++;
         OP_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
         OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // driver: new transaction presented at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (cmd_queue.size() != 0 &&
                      !(cmd_queue[0].drain && expected_rsp.size() != 0)) begin
            req_payload <= cmd_queue[0].req;
            idle_left <= cmd_queue[0].gap;
            start <= 1'b1;
            void'(cmd_queue.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: responses checked before the new transaction is predicted
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               $error("response with none expected: status=%0d read_value=%0h length=%0d",
                      rsp_payload.status, rsp_payload.read_value, rsp_payload.length);
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  error_count++;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %0h, got %0h",
                         want.read_value, rsp_payload.read_value);
                  error_count++;
               end
               if (rsp_payload.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_payload.length);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(apply_list_op(req_payload));
         req_taken <= start && !busy;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("positional_list_insert_delete_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned seg_len;
      int unsigned r;
      int unsigned q;
      int unsigned hi;
      bit          grow;
      bit          no_idle;
      logic [2:0]  op;
      logic [7:0]  pos;

      // directed: empty list, boundaries, shifts, unused codes
      add_cmd(OP_READ, 8'd1, 8'h00, 0, 0);
      add_cmd(OP_DELETE, 8'd1, 8'h00, 1, 0);
      add_cmd(OP_INSERT, 8'd0, 8'h11, 0, 0);
      add_cmd(OP_INSERT, 8'd2, 8'h22, 0, 0);
      add_cmd(OP_INSERT, 8'd1, 8'hFF, 0, 0);
      add_cmd(OP_APPEND, 8'hFF, 8'h00, 2, 0);
      add_cmd(OP_INSERT, 8'd3, 8'h5A, 0, 0);
      add_cmd(OP_INSERT, 8'd2, 8'hA5, 0, 0);
      add_cmd(OP_READ, 8'd1, 8'hFF, 0, 0);
      add_cmd(OP_READ, 8'd4, 8'h00, 0, 1);
      add_cmd(OP_READ, 8'd5, 8'h00, 0, 0);
      add_cmd(OP_READ, 8'hFF, 8'h00, 0, 0);
      add_cmd(OP_READ, 8'd0, 8'h00, 3, 0);
      add_cmd(OP_DELETE, 8'd0, 8'h00, 0, 0);
      add_cmd(OP_DELETE, 8'd5, 8'h00, 0, 0);
      add_cmd(OP_DELETE, 8'd2, 8'h00, 0, 0);
      add_cmd(OP_DELETE, 8'd3, 8'h00, 0, 0);
      add_cmd(FIRST_UNUSED_OP, 8'hAA, 8'h55, 0, 0);
      add_cmd(FIRST_UNUSED_OP + 3'd1, 8'h55, 8'hAA, 0, 0);
      add_cmd(LAST_UNUSED_OP, 8'hFF, 8'hFF, 0, 0);
      add_cmd(OP_READ, 8'd2, 8'h00, 0, 0);
      add_cmd(OP_CLEAR, 8'hFF, 8'hFF, 0, 0);
      add_cmd(OP_READ, 8'd1, 8'h00, 0, 1);

      // random: segments biased to fill the list or to drain it
      while (cmd_queue.size() < RANDOM_OPS + 23) begin
         seg_len = $urandom_range(8, 40);
         grow = $urandom_range(0, 1);
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)
            add_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    no_idle ? 0 : pick_gap(), 0);
         for (int i = 0; i < seg_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               op = OP_CLEAR;
            else if (r < 4)
               op = 3'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
            else if (grow)
               op = (r < 34) ? OP_APPEND : (r < 69) ? OP_INSERT : (r < 82) ? OP_DELETE : OP_READ;
            else
               op = (r < 14) ? OP_APPEND : (r < 26) ? OP_INSERT : (r < 71) ? OP_DELETE : OP_READ;
            hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
            q = $urandom_range(0, 9);
            if (q < 7)
               pos = 8'($urandom_range(1, (hi == 0) ? 1 : hi));
            else if (q == 7)
               case ($urandom_range(0, 2))
                  0: pos = 8'd0;
                  1: pos = 8'(hi + 1);
                  default: pos = 8'hFF;
               endcase
            else
               pos = 8'($urandom_range(0, 255));
            add_cmd(op, pos, 8'($urandom_range(0, 255)), no_idle ? 0 : pick_gap(),
                    $urandom_range(0, 99) == 0);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (cmd_queue.size() != 0 || start || expected_rsp.size() != 0);
      repeat (END_QUIET_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("positional_list_insert_delete_core_tb: PASS");
      else
         $display("positional_list_insert_delete_core_tb: FAIL");
      $finish;
   end

endmodule

// ----- positional_list_insert_delete_core.f -----
sv/plist_pkg.sv
sv/plist_cell.sv
sv/positional_list_insert_delete_core.sv
verif/positional_list_insert_delete_core_tb.sv
